FILE: sv/m4m_pkg.sv
// ----------------------------------------------------------------------------
// m4m_pkg
// Shared types and command codes for the 4x4 fixed point matrix multiplier.
// ----------------------------------------------------------------------------
package m4m_pkg;

  localparam logic [1:0] CMD_LOAD_A   = 2'd0;
  localparam logic [1:0] CMD_LOAD_B   = 2'd1;
  localparam logic [1:0] CMD_MULTIPLY = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         product_index;
    logic signed [31:0] product_value;
    logic               saturated;
    logic               last_of_run;
  } out_beat_t;

  // issue tag that travels alongside each read pair through the mac pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

FILE: sv/m4m_store.sv
// ----------------------------------------------------------------------------
// m4m_store
// Element memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module m4m_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [31:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/m4m_mac.sv
// ----------------------------------------------------------------------------
// m4m_mac
// Shared multiply-accumulate unit: registered 32x32 product, exact wide
// accumulate, then floor shift and saturation to 32 bits.
// ----------------------------------------------------------------------------
module m4m_mac #(
  parameter int MATRIX_DIM    = 4,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  m4m_pkg::mac_ctl_t  ctl,
  input  logic [31:0]        a_data,
  input  logic [31:0]        b_data,
  output logic               done,
  output logic signed [31:0] value,
  output logic               sat
);
  import m4m_pkg::*;

  localparam int ACC_W = 64 + $clog2(MATRIX_DIM) + 1;

  mac_ctl_t                 s1_r;
  mac_ctl_t                 s2_r;
  logic                     done_r;
  logic signed [63:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-32:0]        upper;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r <= ctl;
      s2_r <= s1_r;
      if (ctl.valid && ctl.first) begin
        done_r <= 1'b0;
      end else if (s2_r.valid && s2_r.last) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r.valid) begin
      prod_r <= $signed(a_data) * $signed(b_data);
    end
    if (s2_r.valid) begin
      acc_r <= s2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // all bits above bit 31 must match the sign for the value to fit
  always_comb begin
    shifted = acc_r >>> FRACTION_BITS;
    upper   = shifted[ACC_W-1:31];
    if ((&upper) || !(|upper)) begin
      value = shifted[31:0];
      sat   = 1'b0;
    end else if (shifted[ACC_W-1]) begin
      value = 32'sh8000_0000;
      sat   = 1'b1;
    end else begin
      value = 32'sh7FFF_FFFF;
      sat   = 1'b1;
    end
  end

  assign done = done_r;

endmodule

FILE: sv/m4m_seq.sv
// ----------------------------------------------------------------------------
// m4m_seq
// Sequencer: walks product elements in column-major order, issues one
// operand read pair per cycle for each inner term, then hands off the result.
// ----------------------------------------------------------------------------
module m4m_seq #(
  parameter int MATRIX_DIM = 4,
  parameter int IDX_W      = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              done,
  input  logic              out_free,
  output logic              busy,
  output m4m_pkg::mac_ctl_t ctl,
  output logic [IDX_W-1:0]  a_addr,
  output logic [IDX_W-1:0]  b_addr,
  output logic              emit,
  output logic [IDX_W-1:0]  pos,
  output logic              last
);
  import m4m_pkg::*;

  localparam int DIM_W = $clog2(MATRIX_DIM);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MATRIX_DIM - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [DIM_W-1:0] r_r, r_nxt;
  logic [DIM_W-1:0] c_r, c_nxt;
  logic [DIM_W-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  assign a_addr = IDX_W'(int'(r_r) + MATRIX_DIM * int'(k_r));
  assign b_addr = IDX_W'(MATRIX_DIM * int'(c_r) + int'(k_r));
  assign pos    = IDX_W'(int'(r_r) + MATRIX_DIM * int'(c_r));
  assign last   = (r_r == DIM_MAX) && (c_r == DIM_MAX);
  assign busy   = (state_r != S_IDLE);
  assign emit   = (state_r == S_EMIT) && done && out_free;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        ctl.valid = 1'b1;
        ctl.first = (k_r == '0);
        ctl.last  = (k_r == DIM_MAX);
        if (k_r == DIM_MAX) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_ISSUE;
          if (r_r == DIM_MAX) begin
            r_nxt = '0;
            if (c_r == DIM_MAX) begin
              state_nxt = S_IDLE;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Column-major Q16.16 matrix multiplier with element load and multiply
// commands, one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A load beat writes one element of A or B. A multiply beat holds the input
// stalled while all MATRIX_DIM*MATRIX_DIM product elements are formed
// through the single 32x32 multiplier and wide accumulator, and for longer
// while the output is stalled. Products are emitted in column-major order,
// the final one with last_of_run set.
module matrix4x4_multiply #(
  parameter int MATRIX_DIM    = 4,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  m4m_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output m4m_pkg::out_beat_t  out_beat
);
  import m4m_pkg::*;

  localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;
  localparam int IDX_W = $clog2(ELEMS);

  logic               in_fire;
  logic               load_ok;
  logic               wr_a, wr_b;
  logic               start;
  logic [IDX_W-1:0]   wr_addr;
  logic               busy;
  mac_ctl_t           ctl;
  logic [IDX_W-1:0]   a_addr, b_addr;
  logic [31:0]        a_data, b_data;
  logic               done;
  logic signed [31:0] mac_value;
  logic               mac_sat;
  logic               out_free;
  logic               emit;
  logic [IDX_W-1:0]   pos;
  logic               last;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_beat_r;

  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;
  assign load_ok  = 32'(in_beat.element_index) < ELEMS;
  assign wr_addr  = IDX_W'(in_beat.element_index);
  assign wr_a     = in_fire && (in_beat.command == CMD_LOAD_A) && load_ok;
  assign wr_b     = in_fire && (in_beat.command == CMD_LOAD_B) && load_ok;
  assign start    = in_fire && (in_beat.command == CMD_MULTIPLY);

  m4m_store #(.DEPTH(ELEMS), .IDX_W(IDX_W)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_beat.element_value),
    .rd_en   (ctl.valid),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  m4m_store #(.DEPTH(ELEMS), .IDX_W(IDX_W)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_beat.element_value),
    .rd_en   (ctl.valid),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  m4m_seq #(.MATRIX_DIM(MATRIX_DIM), .IDX_W(IDX_W)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .done     (done),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl),
    .a_addr   (a_addr),
    .b_addr   (b_addr),
    .emit     (emit),
    .pos      (pos),
    .last     (last)
  );

  m4m_mac #(.MATRIX_DIM(MATRIX_DIM), .FRACTION_BITS(FRACTION_BITS)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .a_data (a_data),
    .b_data (b_data),
    .done   (done),
    .value  (mac_value),
    .sat    (mac_sat)
  );

  // output slot is free when empty or its beat leaves this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat_r.product_index <= 4'(pos);
      out_beat_r.product_value <= mac_value;
      out_beat_r.saturated     <= mac_sat;
      out_beat_r.last_of_run   <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: sv/m4m_checker.sv
// ----------------------------------------------------------------------------
// m4m_checker
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module m4m_checker #(
  parameter int MATRIX_DIM = 4
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input m4m_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input logic               out_stall,
  input m4m_pkg::out_beat_t out_beat
);
  import m4m_pkg::*;

  localparam logic [3:0] LAST_POS = 4'(MATRIX_DIM * MATRIX_DIM - 1);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // an accepted multiply beat is followed by a stalled input
  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_beat.command == CMD_MULTIPLY |=> in_stall)
    else $error("input not stalled after multiply");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.last_of_run |-> out_beat.product_index == LAST_POS)
    else $error("last flag on wrong element");

  // the cycle the final element first shows, the run has released the input
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid && out_beat.last_of_run) |-> !in_stall)
    else $error("input still stalled after final element");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.saturated |->
      out_beat.product_value == 32'sh7FFF_FFFF ||
      out_beat.product_value == 32'sh8000_0000)
    else $error("saturated flag with unclipped value");

endmodule

bind matrix4x4_multiply m4m_checker #(.MATRIX_DIM(MATRIX_DIM)) u_m4m_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
